/* rtl/merge_sorter_with_compare_count_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the merge sorter
// Shared property forms. They use the clk and rst_n of the module that
// expands them.
// ----------------------------------------------------------------------------
`ifndef MERGE_SORTER_WITH_COMPARE_COUNT_ASSERT_SVH
`define MERGE_SORTER_WITH_COMPARE_COUNT_ASSERT_SVH

// same-cycle implication
`define MSC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/msc_pkg.sv */
// ----------------------------------------------------------------------------
// msc_pkg
// Shared constants, datapath opcodes and status bundle of the merge sorter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package msc_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int KEY_WIDTH_DEF = 32;
    localparam int KEY_WIDTH_MAX = 64;
    localparam int KEY_FIELD_W   = 32;
    localparam int CNT_W         = 9;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_SORT_INIT,
        DP_MERGE_INIT,
        DP_MERGE_READ,
        DP_MERGE_STEP,
        DP_COPY_READ,
        DP_COPY_WRITE,
        DP_EMIT_READ,
        DP_EMIT_LOAD
    } dp_op_t;

    typedef struct packed {
        logic multi;       // block holds more than one key
        logic merge_last;  // current merge step writes the run's last slot
        logic copy_last;   // current copy step writes the run's last slot
        logic out_fire;    // result request taken this cycle
        logic run_done;    // pending result is the last of the block
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/msc_datapath.sv */
// ----------------------------------------------------------------------------
// msc_datapath
// Key and scratch memories, merge pointers, comparison counter, output regs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "merge_sorter_with_compare_count_assert.svh"

module msc_datapath
    import msc_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire dp_op_t                       op,
    input  wire logic [$clog2(MAX_ITEMS)-1:0] lo,
    input  wire logic [$clog2(MAX_ITEMS)-1:0] mid,
    input  wire logic [$clog2(MAX_ITEMS)-1:0] hi,
    input  wire logic [KEY_FIELD_W-1:0]       key,
    output dp_status_t                        status,
    output logic [$clog2(MAX_ITEMS)-1:0]      last_index,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [KEY_FIELD_W-1:0]            sorted_key,
    output logic                              end_of_run,
    output logic [CNT_W-1:0]                  compare_total,
    output logic                              overflowed
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int PW = AW + 1;
    localparam logic [CW-1:0]    FULL_C  = CW'(MAX_ITEMS);
    localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

    logic [KEY_WIDTH-1:0] key_mem     [MAX_ITEMS];
    logic [KEY_WIDTH-1:0] scratch_mem [MAX_ITEMS];

    logic [CW-1:0]    fill_reg, fill_next;
    logic             drop_reg, drop_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [AW-1:0]    k_reg, k_next;
    logic             out_valid_reg, out_valid_next;
    logic [PW-1:0]    a_reg, a_next;
    logic [PW-1:0]    b_reg, b_next;
    logic [AW-1:0]    w_reg, w_next;
    logic [AW-1:0]    t_reg, t_next;

    logic [KEY_WIDTH-1:0]   key_rd_a, key_rd_b, scr_rd;
    logic [KEY_FIELD_W-1:0] key_out_reg;
    logic                   end_reg;
    logic [CNT_W-1:0]       cnt_out_reg;
    logic                   ovf_reg;

    logic [KEY_WIDTH_MAX-1:0] key_wide, rd_wide;
    logic [KEY_WIDTH-1:0]     key_in;
    logic                     key_we;
    logic [AW-1:0]            key_waddr;
    logic [KEY_WIDTH-1:0]     key_wdata;
    logic                     rd_a_en;
    logic [AW-1:0]            rd_a_addr;
    logic                     left_ok, right_ok, take_left;
    logic [KEY_WIDTH-1:0]     merge_data;
    logic                     out_fire;
    logic [CW-1:0]            k_plus1;
    logic [CW-1:0]            fill_m1;

    // key width adaption: zero extend or truncate through a wide word
    always_comb
    begin
        key_wide = '0;
        key_wide[KEY_FIELD_W-1:0] = key;
        rd_wide = '0;
        rd_wide[KEY_WIDTH-1:0] = key_rd_a;
    end
    assign key_in = key_wide[KEY_WIDTH-1:0];

    // merge decision: left only when strictly less
    assign left_ok    = a_reg <= PW'(mid);
    assign right_ok   = b_reg <= PW'(hi);
    assign take_left  = left_ok && (!right_ok || (key_rd_a < key_rd_b));
    assign merge_data = take_left ? key_rd_a : key_rd_b;
    assign out_fire   = out_valid_reg && out_ready;
    assign k_plus1    = CW'(k_reg) + 1'b1;
    assign fill_m1    = fill_reg - 1'b1;

    // key memory port muxing
    always_comb
    begin
        key_we    = (op == DP_LOAD) && (fill_reg < FULL_C);
        key_waddr = fill_reg[AW-1:0];
        key_wdata = key_in;
        if (op == DP_COPY_WRITE)
        begin
            key_we    = 1'b1;
            key_waddr = t_reg;
            key_wdata = scr_rd;
        end
        rd_a_en   = (op == DP_MERGE_READ) || (op == DP_EMIT_READ);
        rd_a_addr = (op == DP_EMIT_READ) ? k_reg : a_reg[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr] <= key_wdata;
        end
        if (rd_a_en)
        begin
            key_rd_a <= key_mem[rd_a_addr];
        end
        if (op == DP_MERGE_READ)
        begin
            key_rd_b <= key_mem[b_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == DP_MERGE_STEP)
        begin
            scratch_mem[w_reg] <= merge_data;
        end
        if (op == DP_COPY_READ)
        begin
            scr_rd <= scratch_mem[t_reg];
        end
    end

    always_comb
    begin
        fill_next      = fill_reg;
        drop_next      = drop_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        w_next         = w_reg;
        t_next         = t_reg;
        case (op)
            DP_LOAD:
            begin
                if (fill_reg < FULL_C)
                begin
                    fill_next = fill_reg + 1'b1;
                end
                else
                begin
                    drop_next = 1'b1;
                end
            end
            DP_SORT_INIT:
            begin
                cnt_next = '0;
                k_next   = '0;
            end
            DP_MERGE_INIT:
            begin
                a_next = PW'(lo);
                b_next = PW'(mid) + 1'b1;
                w_next = lo;
                t_next = lo;
            end
            DP_MERGE_STEP:
            begin
                if (take_left)
                begin
                    a_next = a_reg + 1'b1;
                end
                else
                begin
                    b_next = b_reg + 1'b1;
                end
                w_next = w_reg + 1'b1;
                // tail copies are not counted
                if (left_ok && right_ok && (cnt_reg != CNT_SAT))
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            DP_COPY_WRITE:
            begin
                t_next = t_reg + 1'b1;
            end
            DP_EMIT_LOAD:
            begin
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (out_fire)
        begin
            out_valid_next = 1'b0;
            if (end_reg)
            begin
                k_next    = '0;
                fill_next = '0;
                drop_next = 1'b0;
            end
            else
            begin
                k_next = k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            drop_reg      <= 1'b0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            w_reg         <= '0;
            t_reg         <= '0;
        end
        else
        begin
            fill_reg      <= fill_next;
            drop_reg      <= drop_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            w_reg         <= w_next;
            t_reg         <= t_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (op == DP_EMIT_LOAD)
        begin
            key_out_reg <= rd_wide[KEY_FIELD_W-1:0];
            end_reg     <= (k_plus1 == fill_reg);
            cnt_out_reg <= cnt_reg;
            ovf_reg     <= drop_reg;
        end
    end

    assign status.multi      = fill_reg > CW'(1);
    assign status.merge_last = (w_reg == hi);
    assign status.copy_last  = (t_reg == hi);
    assign status.out_fire   = out_fire;
    assign status.run_done   = end_reg;
    assign last_index        = fill_m1[AW-1:0];

    assign out_valid     = out_valid_reg;
    assign sorted_key    = key_out_reg;
    assign end_of_run    = end_reg;
    assign compare_total = cnt_out_reg;
    assign overflowed    = ovf_reg;

    `MSC_ASSERT_IMPLY(a_drop_full, drop_reg, fill_reg == FULL_C, "drop flag set below capacity")
    `MSC_ASSERT_IMPLY(a_load_quiet, op == DP_LOAD, !out_valid_reg, "key loaded with result pending")
    `MSC_ASSERT_IMPLY(a_merge_bounds, op == DP_MERGE_STEP, (left_ok || right_ok) && (a_reg <= PW'(mid) + 1'b1) && (b_reg <= PW'(hi) + 1'b1), "merge pointer out of run")

endmodule

`default_nettype wire

/* rtl/msc_ctrl.sv */
// ----------------------------------------------------------------------------
// msc_ctrl
// Sort sequencer: load/emit handshake and a frame stack that walks the
// top-down split tree, issuing one datapath opcode per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "merge_sorter_with_compare_count_assert.svh"

module msc_ctrl
    import msc_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         final_item,
    input  wire dp_status_t                   status,
    input  wire logic [$clog2(MAX_ITEMS)-1:0] last_index,
    output dp_op_t                            op,
    output logic [$clog2(MAX_ITEMS)-1:0]      lo,
    output logic [$clog2(MAX_ITEMS)-1:0]      mid,
    output logic [$clog2(MAX_ITEMS)-1:0]      hi
);

    localparam int AW  = $clog2(MAX_ITEMS);
    localparam int SD  = $clog2(MAX_ITEMS) + 1;
    localparam int SPW = $clog2(SD);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_NODE,
        S_MRG_RD,
        S_MRG_STEP,
        S_CPY_RD,
        S_CPY_WR,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } state_t;

    typedef enum logic [1:0] {
        PH_LEFT,
        PH_RIGHT,
        PH_MERGE
    } phase_t;

    typedef struct packed {
        logic [AW-1:0] lo;
        logic [AW-1:0] hi;
        phase_t        phase;
    } frame_t;

    state_t         state_reg, state_next;
    frame_t         cur_reg, cur_next;
    logic [SPW-1:0] sp_reg, sp_next;
    frame_t         stack_reg [SD];
    logic           push;
    frame_t         push_frame;
    logic [AW:0]    mid_sum;
    logic [AW-1:0]  mid_p1;

    assign lo      = cur_reg.lo;
    assign hi      = cur_reg.hi;
    assign mid_sum = ({1'b0, cur_reg.lo} + {1'b0, cur_reg.hi}) >> 1;
    assign mid     = mid_sum[AW-1:0];
    assign mid_p1  = mid + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        sp_next    = sp_reg;
        push       = 1'b0;
        push_frame = cur_reg;
        op         = DP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op = DP_LOAD;
                    if (final_item)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                op             = DP_SORT_INIT;
                sp_next        = '0;
                cur_next.lo    = '0;
                cur_next.hi    = last_index;
                cur_next.phase = PH_LEFT;
                state_next     = status.multi ? S_NODE : S_EMIT_RD;
            end
            S_NODE:
            begin
                case (cur_reg.phase)
                    PH_LEFT:
                    begin
                        // descend into the left half unless it is one key
                        if (cur_reg.lo < mid)
                        begin
                            push             = 1'b1;
                            push_frame.phase = PH_RIGHT;
                            sp_next          = sp_reg + 1'b1;
                            cur_next.hi      = mid;
                            cur_next.phase   = PH_LEFT;
                        end
                        else
                        begin
                            cur_next.phase = PH_RIGHT;
                        end
                    end
                    PH_RIGHT:
                    begin
                        if (mid_p1 < cur_reg.hi)
                        begin
                            push             = 1'b1;
                            push_frame.phase = PH_MERGE;
                            sp_next          = sp_reg + 1'b1;
                            cur_next.lo      = mid_p1;
                            cur_next.phase   = PH_LEFT;
                        end
                        else
                        begin
                            cur_next.phase = PH_MERGE;
                        end
                    end
                    PH_MERGE:
                    begin
                        op         = DP_MERGE_INIT;
                        state_next = S_MRG_RD;
                    end
                    default:
                    begin
                        cur_next.phase = PH_MERGE;
                    end
                endcase
            end
            S_MRG_RD:
            begin
                op         = DP_MERGE_READ;
                state_next = S_MRG_STEP;
            end
            S_MRG_STEP:
            begin
                op         = DP_MERGE_STEP;
                state_next = status.merge_last ? S_CPY_RD : S_MRG_RD;
            end
            S_CPY_RD:
            begin
                op         = DP_COPY_READ;
                state_next = S_CPY_WR;
            end
            S_CPY_WR:
            begin
                op         = DP_COPY_WRITE;
                state_next = S_CPY_RD;
                if (status.copy_last)
                begin
                    if (sp_reg == '0)
                    begin
                        state_next = S_EMIT_RD;
                    end
                    else
                    begin
                        cur_next   = stack_reg[sp_reg - 1'b1];
                        sp_next    = sp_reg - 1'b1;
                        state_next = S_NODE;
                    end
                end
            end
            S_EMIT_RD:
            begin
                op         = DP_EMIT_READ;
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                op         = DP_EMIT_LOAD;
                state_next = S_EMIT_WAIT;
            end
            S_EMIT_WAIT:
            begin
                if (status.out_fire)
                begin
                    state_next = status.run_done ? S_IDLE : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cur_reg   <= '0;
            sp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            sp_reg    <= sp_next;
        end
    end

    // parent frames
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_reg[sp_reg] <= push_frame;
        end
    end

    `MSC_ASSERT_IMPLY(a_stack_room, push, sp_reg < SPW'(SD - 1), "frame stack overflow")
    `MSC_ASSERT_IMPLY(a_step_after_read, state_reg == S_MRG_STEP, $past(state_reg) == S_MRG_RD, "merge step without read")
    `MSC_ASSERT_NEXT(a_sort_done, (state_reg == S_CPY_WR) && status.copy_last && (sp_reg == '0), state_reg == S_EMIT_RD, "emit not started after root merge")

endmodule

`default_nettype wire

/* rtl/merge_sorter_with_compare_count.sv */
// ----------------------------------------------------------------------------
// merge_sorter_with_compare_count
// Block merge sorter: loads keys, top-down merge sorts them, streams them out
// in ascending order with the merge comparison count of the block.
//
// Input channel (in_valid/in_ready, key, final_item): one key per request,
// one request per cycle while loading. The request with final_item set
// closes the block. Keys past MAX_ITEMS are dropped and flagged.
// Output channel (out_valid/out_ready): one sorted key per request, with
// end_of_run on the last, compare_total and overflowed on every request.
// Sequence: after the closing key, the sort walks the split tree, visiting
// each split node in its left, right and merge-setup steps, merges each run
// key by key (read, then step) and copies it back key by key (read, then
// write) through the single-write key memory. Emission then reads, loads
// and offers one key at a time, fetching the next only once it is taken.
// in_ready is low from the closing key until the last result is taken, so
// one block is handled at a time.
// A stalled receiver holds the current result; the sorter waits.
// Reset clears fill count, drop flag, counter and sequencer; the key
// memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module merge_sorter_with_compare_count
    import msc_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [KEY_FIELD_W-1:0] key,
    input  wire logic                   final_item,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [KEY_FIELD_W-1:0]      sorted_key,
    output logic                        end_of_run,
    output logic [CNT_W-1:0]            compare_total,
    output logic                        overflowed
);

    localparam int AW = $clog2(MAX_ITEMS);

    dp_op_t        op;
    dp_status_t    status;
    logic [AW-1:0] lo, mid, hi;
    logic [AW-1:0] last_index;

    // sequencer: handshake, split-tree walk, opcode per cycle
    msc_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .final_item (final_item),
        .status     (status),
        .last_index (last_index),
        .op         (op),
        .lo         (lo),
        .mid        (mid),
        .hi         (hi)
    );

    // memories, merge pointers, comparison counter, result registers
    msc_datapath #(
        .MAX_ITEMS (MAX_ITEMS),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .lo            (lo),
        .mid           (mid),
        .hi            (hi),
        .key           (key),
        .status        (status),
        .last_index    (last_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sorted_key    (sorted_key),
        .end_of_run    (end_of_run),
        .compare_total (compare_total),
        .overflowed    (overflowed)
    );

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Block-level test of merge_sorter_with_compare_count. Blocks of keys are
// loaded and their sorted output checked key by key, together with the last
// marker, the merge comparison count and the overflow flag. Expected values
// come from a top-down merge sort model kept inside this bench. Both
// handshakes are throttled at random, with one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import msc_pkg::*;

    localparam int CAPACITY    = MAX_ITEMS_DEF;
    localparam int COUNT_SAT   = (1 << CNT_W) - 1;
    localparam int ITEM_TARGET = 210;
    localparam int TAIL_CYCLES = 16;

    // one sorted key as the block should emit it
    typedef struct {
        logic [KEY_FIELD_W-1:0] key_value;
        logic                   last_key;
        logic [CNT_W-1:0]       compares;
        logic                   dropped;
    } sorted_result_t;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   in_valid   = 1'b0;
    logic                   in_ready;
    logic [KEY_FIELD_W-1:0] key        = '0;
    logic                   final_item = 1'b0;
    logic                   out_valid;
    logic                   out_ready  = 1'b0;
    logic [KEY_FIELD_W-1:0] sorted_key;
    logic                   end_of_run;
    logic [CNT_W-1:0]       compare_total;
    logic                   overflowed;

    // model state: the block being loaded and the merge buffer
    logic [KEY_FIELD_W-1:0] block_keys [CAPACITY];
    logic [KEY_FIELD_W-1:0] merge_buf  [CAPACITY];
    int                     block_fill;
    logic                   block_dropped;
    int                     merge_compares;

    sorted_result_t         sorted_expect [$];
    int                     items_sent;
    int                     mismatches;
    bit                     idle_on;         // random gaps on both channels
    int                     rx_hold_request; // long receiver hold-off, in cycles

    merge_sorter_with_compare_count #(
        .MAX_ITEMS (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH_DEF)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .key           (key),
        .final_item    (final_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sorted_key    (sorted_key),
        .end_of_run    (end_of_run),
        .compare_total (compare_total),
        .overflowed    (overflowed)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Sort model
    // ------------------------------------------------------------------

    // Merge [lo..mid] with [mid+1..hi]. Left key wins only when strictly
    // less, so equal keys come from the right run first. Only head-to-head
    // comparisons count; tail copies do not.
    function automatic void merge_halves(input int lo, input int mid, input int hi);
        int a;
        int b;
        int w;
        a = lo;
        b = mid + 1;
        w = lo;
        while (a <= mid && b <= hi) begin
            if (block_keys[a] < block_keys[b]) begin
                merge_buf[w] = block_keys[a];
                a++;
            end
            else begin
                merge_buf[w] = block_keys[b];
                b++;
            end
            w++;
            if (merge_compares < COUNT_SAT)
                merge_compares++;
        end
        while (a <= mid) begin
            merge_buf[w] = block_keys[a];
            a++;
            w++;
        end
        while (b <= hi) begin
            merge_buf[w] = block_keys[b];
            b++;
            w++;
        end
        for (int t = lo; t <= hi; t++)
            block_keys[t] = merge_buf[t];
    endfunction

    function automatic void sort_span(input int lo, input int hi);
        int mid;
        if (lo >= hi)
            return;
        mid = (lo + hi) / 2;
        sort_span(lo, mid);
        sort_span(mid + 1, hi);
        merge_halves(lo, mid, hi);
    endfunction

    // Take one accepted key into the block. The closing key (even when it
    // is itself dropped for lack of room) sorts the block and queues the
    // whole sorted output.
    function automatic void absorb_key(input logic [KEY_FIELD_W-1:0] k, input logic last);
        sorted_result_t r;
        if (block_fill < CAPACITY) begin
            block_keys[block_fill] = k;
            block_fill++;
        end
        else
            block_dropped = 1'b1;
        if (!last)
            return;
        merge_compares = 0;
        if (block_fill > 1)
            sort_span(0, block_fill - 1);
        for (int i = 0; i < block_fill; i++) begin
            r.key_value = block_keys[i];
            r.last_key  = (i == block_fill - 1);
            r.compares  = merge_compares[CNT_W-1:0];
            r.dropped   = block_dropped;
            sorted_expect.push_back(r);
        end
        block_fill     = 0;
        block_dropped  = 1'b0;
        merge_compares = 0;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // mostly no gap or a short one, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // full-range keys, near-duplicates, the extremes and whole numbers
    function automatic logic [KEY_FIELD_W-1:0] random_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return $urandom;
        if (roll < 75)
            return $urandom_range(0, 5);
        if (roll < 85) begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return '1;
                2:       return 32'h8000_0000;
                default: return 32'h7fff_ffff;
            endcase
        end
        return $urandom_range(0, 16383) << 18;
    endfunction

    // mostly small blocks, a few large ones up to full capacity
    function automatic int pick_block_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 8);
        if (roll < 95)
            return $urandom_range(9, 24);
        return $urandom_range(25, CAPACITY);
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial begin : receiver
        int stall;
        wait (rst_n === 1'b1);
        forever begin
            if (rx_hold_request > 0) begin
                stall = rx_hold_request;
                rx_hold_request = 0;
            end
            else
                stall = pick_gap();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Result check: every taken request against the oldest expectation.
    // Values are read at the edge, before any update of that edge lands.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : result_check
        sorted_result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (sorted_expect.size() == 0) begin
                $error("result request with none expected: sorted_key %0h", sorted_key);
                mismatches++;
            end
            else begin
                want = sorted_expect.pop_front();
                if (sorted_key !== want.key_value) begin
                    $error("sorted_key: expected %0h, got %0h", want.key_value, sorted_key);
                    mismatches++;
                end
                if (end_of_run !== want.last_key) begin
                    $error("end_of_run: expected %0b, got %0b", want.last_key, end_of_run);
                    mismatches++;
                end
                if (compare_total !== want.compares) begin
                    $error("compare_total: expected %0d, got %0d", want.compares,
                           compare_total);
                    mismatches++;
                end
                if (overflowed !== want.dropped) begin
                    $error("overflowed: expected %0b, got %0b", want.dropped, overflowed);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one key request and hold it until taken. Returns in the step of
    // the accepting edge, so a following call may keep valid high.
    task automatic send_key(input logic [KEY_FIELD_W-1:0] k, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        key        <= k;
        final_item <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        absorb_key(k, last);
    endtask

    task automatic send_block(input logic [KEY_FIELD_W-1:0] keys [$]);
        foreach (keys[i])
            send_key(keys[i], i == keys.size() - 1);
    endtask

    // Sender goes quiet until all queued results are out, plus a short tail.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sorted_expect.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Single key, pairs, extremes, equal runs, pre-sorted and reversed
    // input. The first three back to back, the rest with random gaps.
    task automatic test_directed_cases();
        idle_on = 1'b0;
        send_block('{32'h0000_0000});
        send_block('{32'hffff_ffff, 32'h0000_0000});
        send_block('{32'h0000_0005, 32'h0000_0005});
        idle_on = 1'b1;
        send_block('{32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001,
                     32'h0000_0000, 32'h5555_5555, 32'haaaa_aaaa});
        send_block('{32'h0000_0003, 32'h0000_0003, 32'h0000_0003, 32'h0000_0003});
        send_block('{32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0004_0000,
                     32'hffff_fffe});
        send_block('{32'hffff_ffff, 32'h8000_0000, 32'h0000_0000});
        drain_results();
    endtask

    // Full block plus two more keys: one dropped on its own, then the
    // closing key, which is dropped as well but still starts the sort.
    task automatic test_capacity_overflow();
        idle_on = 1'b1;
        for (int i = 0; i < CAPACITY + 2; i++)
            send_key(random_key(), i == CAPACITY + 1);
        drain_results();
    endtask

    // Receiver holds off long while the sender keeps offering the next
    // block, so the sorter sits full of results and refuses input.
    task automatic test_output_backpressure();
        idle_on = 1'b0;
        for (int i = 0; i < 5; i++)
            send_key(random_key(), i == 4);
        rx_hold_request = 200;
        for (int i = 0; i < 6; i++)
            send_key(random_key(), i == 5);
        drain_results();
    endtask

    // Random blocks until the item budget is used; idling switched on and
    // off per block, occasional full drains in between.
    task automatic test_random_blocks();
        int size;
        while (items_sent < ITEM_TARGET) begin
            idle_on = ($urandom_range(0, 3) != 0);
            size = pick_block_size();
            for (int i = 0; i < size; i++)
                send_key(random_key(), i == size - 1);
            if ($urandom_range(0, 5) == 0)
                drain_results();
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        block_fill      = 0;
        block_dropped   = 1'b0;
        merge_compares  = 0;
        items_sent      = 0;
        mismatches      = 0;
        idle_on         = 1'b0;
        rx_hold_request = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_capacity_overflow();
        test_output_backpressure();
        test_random_blocks();

        if (sorted_expect.size() != 0)
            $error("%0d expected results never arrived", sorted_expect.size());
        if (mismatches == 0 && sorted_expect.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
